// File: rtl/core/mlcd_pkg.sv
// Shared constants, types and helper functions for the memory-LCD
// triple-buffer streamer. No dependencies.
`timescale 1ns / 1ps

package mlcd_pkg;

  localparam int LINE_BYTES = 50;
  localparam int TILE_ROWS  = 30;
  localparam int SRC_BYTES  = 16384;
  localparam int DISP_LINES = TILE_ROWS * 8;
  localparam int FRAME_DATA = DISP_LINES * LINE_BYTES;
  localparam int LINE_SLOT  = LINE_BYTES + 2;
  localparam int FRAME_LEN  = 2 + DISP_LINES * LINE_SLOT;
  localparam int FS_DEPTH   = 3 * FRAME_DATA;
  localparam int CLR_LEN    = 2 * FRAME_DATA;
  localparam int FS_AW      = $clog2(FS_DEPTH);
  localparam int SRC_AW     = $clog2(SRC_BYTES);
  localparam int POS_W      = $clog2(FRAME_LEN);
  localparam int DIDX_W     = $clog2(FRAME_DATA);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TILE  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NEXT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_SRC    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    TK_HDR  = 3'd0,
    TK_LNUM = 3'd1,
    TK_DATA = 3'd2,
    TK_ZERO = 3'd3,
    TK_END  = 3'd4
  } tx_kind_e;

  // What the serial sequencer says about the byte at the current position
  typedef struct packed {
    tx_kind_e          kind;
    logic [7:0]        byte_val;
    logic [DIDX_W-1:0] didx;
  } tx_info_t;

  function automatic logic [1:0] frame_sel(input logic [1:0] v);
    frame_sel = (v <= 2'd2) ? v : 2'd0;
  endfunction

  function automatic logic [1:0] other_frame(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    other_frame = (s <= 3'd3) ? frame_sel(2'(3'd3 - s)) : 2'd0;
  endfunction

  function automatic logic [FS_AW-1:0] frame_base(input logic [1:0] f);
    case (frame_sel(f))
      2'd1:    frame_base = FS_AW'(FRAME_DATA);
      2'd2:    frame_base = FS_AW'(2 * FRAME_DATA);
      default: frame_base = '0;
    endcase
  endfunction

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    bit_rev = r;
  endfunction

endpackage

// File: rtl/core/mlcd_tx_seq.sv
// Serial frame sequencer: position, line and offset counters and VCOM phase.
// Depends on mlcd_pkg.
`timescale 1ns / 1ps

module mlcd_tx_seq import mlcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  output tx_info_t info_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [5:0]        off_q, off_d;
  logic [7:0]        line_q, line_d;
  logic [DIDX_W-1:0] didx_q, didx_d;
  logic              vcom_q, vcom_d;

  always_comb begin
    info_o.didx     = didx_q;
    info_o.byte_val = 8'h00;
    if (pos_q == '0) begin
      info_o.kind     = TK_HDR;
      info_o.byte_val = vcom_q ? 8'h80 : 8'hC0;
    end else if (pos_q == POS_W'(FRAME_LEN - 1)) begin
      info_o.kind = TK_END;
    end else if (off_q == '0) begin
      info_o.kind     = TK_LNUM;
      info_o.byte_val = bit_rev(line_q + 8'd1);
    end else if (off_q <= 6'(LINE_BYTES)) begin
      info_o.kind = TK_DATA;
    end else begin
      info_o.kind = TK_ZERO;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    off_d  = off_q;
    line_d = line_q;
    didx_d = didx_q;
    vcom_d = vcom_q;
    if (step_i) begin
      case (info_o.kind)
        TK_HDR: begin
          pos_d  = POS_W'(1);
          off_d  = '0;
          line_d = '0;
          didx_d = '0;
          vcom_d = ~vcom_q;
        end
        TK_END: begin
          pos_d = '0;
        end
        default: begin
          pos_d = pos_q + POS_W'(1);
          if (info_o.kind == TK_DATA) begin
            didx_d = didx_q + DIDX_W'(1);
          end
          if (off_q == 6'(LINE_SLOT - 1)) begin
            off_d  = '0;
            line_d = line_q + 8'd1;
          end else begin
            off_d = off_q + 6'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      off_q  <= '0;
      line_q <= '0;
      didx_q <= '0;
      vcom_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      off_q  <= off_d;
      line_q <= line_d;
      didx_q <= didx_d;
      vcom_q <= vcom_d;
    end
  end

endmodule

// File: rtl/core/memory_lcd_triple_buffer_streamer.sv
// Top level of the memory-LCD triple-buffer streamer: frame and source memories,
// command sequencer, output register. Depends on mlcd_pkg and mlcd_tx_seq.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: command; tdata: tile/load args
// m_axis    out  m_axis_tvalid/tready   tdata: status, tx_byte; tlast: frame_last
//
// Every request ends in S_FIN; next_byte passes S_TXRD first when it reads a
// data byte, tile alternates S_TRD and S_TWR for each byte drawn, and flush
// alternates S_CRD and S_CWR to copy one frame through the single read and
// single write port of the frame memory. After reset a clearing pass writes
// 0xFF into frames 0 and 1; no request is taken meanwhile. A result waiting
// on m_axis stalls only the S_FIN state of the next request.
`timescale 1ns / 1ps

module memory_lcd_triple_buffer_streamer import mlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // src_index[13:0] src_data[21:14] src_width[29:22]
                                     // src_height[37:30] pos_x[43:38] pos_y[48:44]
                                     // draw_cols[54:49] draw_rows[59:55], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0] tx_byte[9:2], zero pad
  output logic        m_axis_tlast   // frame_last
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_TRD   = 8'b0000_0100,
    S_TWR   = 8'b0000_1000,
    S_CRD   = 8'b0001_0000,
    S_CWR   = 8'b0010_0000,
    S_TXRD  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // request fields
  cmd_e        cmd;
  logic [13:0] src_index;
  logic [7:0]  src_data, src_width, src_height;
  logic [5:0]  pos_x, draw_cols;
  logic [4:0]  pos_y, draw_rows;

  assign cmd         = cmd_e'(s_axis_tuser);
  assign src_index   = s_axis_tdata[13:0];
  assign src_data    = s_axis_tdata[21:14];
  assign src_width   = s_axis_tdata[29:22];
  assign src_height  = s_axis_tdata[37:30];
  assign pos_x       = s_axis_tdata[43:38];
  assign pos_y       = s_axis_tdata[48:44];
  assign draw_cols   = s_axis_tdata[54:49];
  assign draw_rows   = s_axis_tdata[59:55];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // frame roles
  logic [1:0] show_q, show_d, pend_q, pend_d, draw_q, draw_d, spare_q, spare_d;

  // memories
  logic [7:0]        fs_mem [FS_DEPTH];
  logic [7:0]        src_mem [SRC_BYTES];
  logic              fs_we, fs_re;
  logic [FS_AW-1:0]  fs_waddr, fs_raddr;
  logic [7:0]        fs_wdata, fs_rdata_q;
  logic [SRC_AW-1:0] src_raddr;
  logic [7:0]        src_rdata_q;

  // serial sequencer
  tx_info_t tx_info;
  logic     tx_step;
  assign tx_step = accept && (cmd == CMD_NEXT);

  mlcd_tx_seq u_tx_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (tx_step),
    .info_o (tx_info)
  );

  // tile walk and copy counters
  logic [14:0]       clr_q, clr_d;
  logic [5:0]        tw_q, tw_d, col_q, col_d;
  logic [7:0]        w_q, w_d, sx_q, sx_d, lines_q, lines_d;
  logic [10:0]       h8_q, h8_d, sline_q, sline_d;
  logic [SRC_AW-1:0] srow_q, srow_d;
  logic [FS_AW-1:0]  dst_q, dst_d, drow_q, drow_d;
  logic [DIDX_W-1:0] cnt_q, cnt_d;
  logic [FS_AW-1:0]  cps_q, cps_d;

  // result register and output stage
  logic [1:0] res_st_q, res_st_d;
  logic [7:0] res_b_q, res_b_d;
  logic       res_l_q, res_l_d;
  logic       ov_q, ov_d;
  logic [1:0] o_st_q, o_st_d;
  logic [7:0] o_b_q, o_b_d;
  logic       o_l_q, o_l_d;
  logic       out_free;
  assign out_free = !ov_q || m_axis_tready;

  // tile checks
  logic        bad_bounds, too_big;
  logic [15:0] area;
  logic [1:0]  draw_new;
  logic [FS_AW-1:0] tile_start;
  assign bad_bounds = (src_width == '0) || (src_height == '0) || (draw_cols == '0) ||
                      (draw_rows == '0) ||
                      ({1'b0, pos_x} + {1'b0, draw_cols} > 7'(LINE_BYTES)) ||
                      ({1'b0, pos_y} + {1'b0, draw_rows} > 6'(TILE_ROWS));
  assign area       = 16'(src_width) * 16'(src_height);
  assign too_big    = area > 16'(SRC_BYTES / 8);
  assign tile_start = frame_base(draw_q) + FS_AW'(pos_y) * FS_AW'(LINE_BYTES * 8)
                      + FS_AW'(pos_x);
  assign draw_new   = frame_sel(spare_q);

  always_comb begin
    state_d  = state_q;
    show_d   = show_q;
    pend_d   = pend_q;
    draw_d   = draw_q;
    spare_d  = spare_q;
    clr_d    = clr_q;
    tw_d     = tw_q;
    col_d    = col_q;
    w_d      = w_q;
    sx_d     = sx_q;
    lines_d  = lines_q;
    h8_d     = h8_q;
    sline_d  = sline_q;
    srow_d   = srow_q;
    dst_d    = dst_q;
    drow_d   = drow_q;
    cnt_d    = cnt_q;
    cps_d    = cps_q;
    res_st_d = res_st_q;
    res_b_d  = res_b_q;
    res_l_d  = res_l_q;
    ov_d     = ov_q && !m_axis_tready;
    o_st_d   = o_st_q;
    o_b_d    = o_b_q;
    o_l_d    = o_l_q;
    fs_we    = 1'b0;
    fs_waddr = dst_q;
    fs_wdata = src_rdata_q;
    fs_re    = 1'b0;
    fs_raddr = cps_q;
    src_raddr = srow_q + SRC_AW'(sx_q);

    case (state_q)
      S_CLEAR: begin
        fs_we    = 1'b1;
        fs_waddr = FS_AW'(clr_q);
        fs_wdata = 8'hFF;
        clr_d    = clr_q + 15'd1;
        if (clr_q == 15'(CLR_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_st_d = ST_OK;
          res_b_d  = 8'h00;
          res_l_d  = 1'b0;
          state_d  = S_FIN;
          case (cmd)
            CMD_LOAD: begin
              // source write happens in the memory block
            end
            CMD_TILE: begin
              if (bad_bounds) begin
                res_st_d = ST_BOUNDS;
              end else if (too_big) begin
                res_st_d = ST_SRC;
              end else begin
                tw_d    = draw_cols;
                col_d   = draw_cols;
                w_d     = src_width;
                h8_d    = {src_height, 3'b000};
                sx_d    = '0;
                sline_d = '0;
                srow_d  = '0;
                lines_d = {draw_rows, 3'b000};
                dst_d   = tile_start;
                drow_d  = tile_start;
                state_d = S_TRD;
              end
            end
            CMD_FLUSH: begin
              pend_d  = frame_sel(draw_q);
              draw_d  = draw_new;
              spare_d = other_frame(draw_new, frame_sel(show_q));
              cps_d   = frame_base(draw_q);
              dst_d   = frame_base(draw_new);
              cnt_d   = '0;
              state_d = S_CRD;
            end
            default: begin
              res_b_d = tx_info.byte_val;
              res_l_d = (tx_info.kind == TK_END);
              if (tx_info.kind == TK_HDR) begin
                show_d  = frame_sel(pend_q);
                spare_d = other_frame(frame_sel(draw_q), frame_sel(pend_q));
              end
              if (tx_info.kind == TK_DATA) begin
                fs_re    = 1'b1;
                fs_raddr = frame_base(show_q) + FS_AW'(tx_info.didx);
                state_d  = S_TXRD;
              end
            end
          endcase
        end
      end
      S_TRD: begin
        state_d = S_TWR;
      end
      S_TWR: begin
        fs_we   = 1'b1;
        state_d = S_TRD;
        if (col_q != 6'd1) begin
          col_d = col_q - 6'd1;
          dst_d = dst_q + FS_AW'(1);
          sx_d  = (sx_q + 8'd1 == w_q) ? 8'd0 : sx_q + 8'd1;
        end else begin
          lines_d = lines_q - 8'd1;
          col_d   = tw_q;
          sx_d    = '0;
          drow_d  = drow_q + FS_AW'(LINE_BYTES);
          dst_d   = drow_q + FS_AW'(LINE_BYTES);
          if (sline_q + 11'd1 == h8_q) begin
            sline_d = '0;
            srow_d  = '0;
          end else begin
            sline_d = sline_q + 11'd1;
            srow_d  = srow_q + SRC_AW'(w_q);
          end
          if (lines_q == 8'd1) begin
            state_d = S_FIN;
          end
        end
      end
      S_CRD: begin
        fs_re   = 1'b1;
        state_d = S_CWR;
      end
      S_CWR: begin
        fs_we    = 1'b1;
        fs_wdata = fs_rdata_q;
        cnt_d    = cnt_q + DIDX_W'(1);
        cps_d    = cps_q + FS_AW'(1);
        dst_d    = dst_q + FS_AW'(1);
        state_d  = (cnt_q == DIDX_W'(FRAME_DATA - 1)) ? S_FIN : S_CRD;
      end
      S_TXRD: begin
        res_b_d = fs_rdata_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          o_st_d  = res_st_q;
          o_b_d   = res_b_q;
          o_l_d   = res_l_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_q <= fs_mem[fs_raddr];
    end
  end

  // source memory
  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_LOAD)) begin
      src_mem[src_index] <= src_data;
    end
    src_rdata_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      show_q  <= 2'd0;
      pend_q  <= 2'd0;
      draw_q  <= 2'd1;
      spare_q <= 2'd2;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      show_q  <= show_d;
      pend_q  <= pend_d;
      draw_q  <= draw_d;
      spare_q <= spare_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tw_q     <= tw_d;
    col_q    <= col_d;
    w_q      <= w_d;
    sx_q     <= sx_d;
    lines_q  <= lines_d;
    h8_q     <= h8_d;
    sline_q  <= sline_d;
    srow_q   <= srow_d;
    dst_q    <= dst_d;
    drow_q   <= drow_d;
    cnt_q    <= cnt_d;
    cps_q    <= cps_d;
    res_st_q <= res_st_d;
    res_b_q  <= res_b_d;
    res_l_q  <= res_l_d;
    o_st_q   <= o_st_d;
    o_b_q    <= o_b_d;
    o_l_q    <= o_l_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, o_b_q, o_st_q};
  assign m_axis_tlast  = o_l_q;

endmodule

// File: rtl/core/mlcd_checker.sv
// Port-level checker for the memory-LCD triple-buffer streamer, with its bind.
// Depends on nothing but the top-level ports.
`timescale 1ns / 1ps

module mlcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // end of frame is a zero byte with ok status
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[9:0] == 10'd0)
    else $error("frame end byte not zero");

  // pad bits and status code range
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0 && m_axis_tdata[1:0] != 2'd3)
    else $error("bad result encoding");

  // a taken request never completes in the same cycle it is accepted
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request port did not close after accept");

endmodule

bind memory_lcd_triple_buffer_streamer mlcd_checker u_mlcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
// Self-checking bench for memory_lcd_triple_buffer_streamer: directed and random
// requests, an in-bench mirror of frames, source and serial state. Needs mlcd_pkg.
`timescale 1ns / 1ps

module tb_top;
  import mlcd_pkg::*;

  localparam int IDLE_LIMIT = 100000;  // clearing pass, full-screen tile or flush fit easily

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = CMD_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  memory_lcd_triple_buffer_streamer uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the block state
  typedef struct {
    status_e    status;
    logic [7:0] tx_byte;
    logic       last;
  } reply_t;

  logic [7:0] frame_mem [3][FRAME_DATA];
  logic [7:0] src_mem [SRC_BYTES];
  bit         src_loaded [SRC_BYTES];
  int         src_prefix;  // bytes 0..src_prefix-1 all loaded
  int         shown, pending, drawing, spare;
  bit         vcom;
  int         tx_pos;

  reply_t reply_q[$];
  int     errors, n_sent, n_checked, n_frames, n_tiles_ok, n_flush;
  bit     quiet;       // no random idling on either side
  int     hold_len;    // long receiver hold-off, picked up by receiver process

  task automatic flag_mismatch(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  function automatic int third_frame(int a, int b);
    int s;
    s = a + b;
    return (s >= 1 && s <= 3) ? 3 - s : 0;
  endfunction

  function automatic status_e mirror_tile(int w, int h, int px, int py, int tw, int th);
    int sy, sx;
    if (w == 0 || h == 0 || tw == 0 || th == 0 ||
        px + tw > LINE_BYTES || py + th > TILE_ROWS)
      return ST_BOUNDS;
    if (w * h * 8 > SRC_BYTES)
      return ST_SRC;
    sy = 0;
    for (int y = py; y < py + th; y++) begin
      for (int yl = 0; yl < 8; yl++) begin
        sx = 0;
        for (int x = px; x < px + tw; x++) begin
          frame_mem[drawing][(y * 8 + yl) * LINE_BYTES + x] = src_mem[(sy * 8 + yl) * w + sx];
          sx = (sx + 1 >= w) ? 0 : sx + 1;
        end
      end
      sy = (sy + 1 >= h) ? 0 : sy + 1;
    end
    return ST_OK;
  endfunction

  function automatic void mirror_flush();
    pending = drawing;
    drawing = spare;
    spare   = third_frame(drawing, shown);
    for (int i = 0; i < FRAME_DATA; i++) frame_mem[drawing][i] = frame_mem[pending][i];
  endfunction

  function automatic reply_t mirror_serial();
    reply_t r;
    int p, q, line, off;
    logic [7:0] lnum;
    r = '{ST_OK, 8'h00, 1'b0};
    p = (tx_pos >= FRAME_LEN) ? 0 : tx_pos;
    if (p == 0) begin
      // frame start: pending frame goes on show, header carries VCOM
      shown     = pending;
      spare     = third_frame(drawing, shown);
      r.tx_byte = vcom ? 8'h80 : 8'hC0;
      vcom      = ~vcom;
      tx_pos    = 1;
      return r;
    end
    if (p == FRAME_LEN - 1) begin
      r.last = 1'b1;
      tx_pos = 0;
      return r;
    end
    q    = p - 1;
    line = q / LINE_SLOT;
    off  = q % LINE_SLOT;
    if (off == 0) begin
      lnum      = 8'(line + 1);
      r.tx_byte = {<<{lnum}};
    end else if (off <= LINE_BYTES) begin
      r.tx_byte = frame_mem[shown][line * LINE_BYTES + off - 1];
    end
    tx_pos = p + 1;
    return r;
  endfunction

  // One request on the input side; the expected reply is queued at acceptance
  task automatic send_req(cmd_e cmd, int idx = 0, int dat = 0, int sw = 0, int sh = 0,
                          int px = 0, int py = 0, int tw = 0, int th = 0);
    reply_t r;
    if (!quiet && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, 5'(th), 6'(tw), 5'(py), 6'(px), 8'(sh), 8'(sw), 8'(dat), 14'(idx)};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = '{ST_OK, 8'h00, 1'b0};
    case (cmd)
      CMD_LOAD: begin
        src_mem[idx]    = 8'(dat);
        src_loaded[idx] = 1'b1;
        while (src_prefix < SRC_BYTES && src_loaded[src_prefix]) src_prefix++;
      end
      CMD_TILE: begin
        r.status = mirror_tile(sw, sh, px, py, tw, th);
        if (r.status == ST_OK) n_tiles_ok++;
      end
      CMD_FLUSH: begin
        mirror_flush();
        n_flush++;
      end
      default: begin
        r = mirror_serial();
        if (r.last) n_frames++;
      end
    endcase
    reply_q.push_back(r);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // Random tile whose source area is fully loaded; mostly small
  task automatic random_tile();
    int w, h;
    w = $urandom_range(1, 16);
    h = $urandom_range(1, 4);
    while (w * h * 8 > src_prefix) w = (w > 1) ? w - 1 : 1;
    send_req(CMD_TILE, $urandom, $urandom, w, h, $urandom_range(0, 45), $urandom_range(0, 27),
             $urandom_range(1, 5), $urandom_range(1, 3));
  endtask

  // Receiver: checks every accepted reply, then decides next ready
  int hold_left;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected reply", m_axis_tdata, 0);
      end else begin
        reply_t w;
        w = reply_q.pop_front();
        n_checked++;
        if (m_axis_tdata[1:0] != w.status) flag_mismatch("status", m_axis_tdata[1:0], w.status);
        if (m_axis_tdata[9:2] != w.tx_byte) flag_mismatch("tx_byte", m_axis_tdata[9:2], w.tx_byte);
        if (m_axis_tlast != w.last) flag_mismatch("frame_last", m_axis_tlast, w.last);
      end
    end
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog on cycles with no handshake on either side
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---- tests ----

  // Source prefix with random pixels, the column that the capacity-limit tile
  // reads, plus both ends of the address range
  task automatic test_source_load();
    for (int i = 0; i < 96; i++) send_req(CMD_LOAD, i, $urandom);
    for (int i = 0; i < 8; i++) send_req(CMD_LOAD, i * 64, $urandom);
    send_req(CMD_LOAD, SRC_BYTES - 1, 8'hFF);
    send_req(CMD_LOAD, 14'h2AAA, 8'h00);
    send_req(CMD_LOAD, 14'h1555, 8'hA5);
  endtask

  // Run of serial bytes: header, line numbers, data, trailers
  task automatic test_serial_bytes(int count);
    for (int i = 0; i < count; i++) send_req(CMD_NEXT);
  endtask

  task automatic test_tile_args();
    send_req(CMD_TILE, 0, 0, 0, 1, 0, 0, 1, 1);        // zero source width
    send_req(CMD_TILE, 0, 0, 1, 0, 0, 0, 1, 1);        // zero source height
    send_req(CMD_TILE, 0, 0, 1, 1, 0, 0, 0, 1);        // zero tile width
    send_req(CMD_TILE, 0, 0, 1, 1, 0, 0, 1, 0);        // zero tile height
    send_req(CMD_TILE, 0, 0, 1, 1, 49, 0, 2, 1);       // past last column
    send_req(CMD_TILE, 0, 0, 1, 1, 0, 29, 1, 2);       // past last row
    send_req(CMD_TILE, 0, 0, 1, 1, 63, 31, 63, 31);    // all position bits set
    send_req(CMD_TILE, 0, 0, 255, 255, 0, 0, 1, 1);    // source too small
    send_req(CMD_TILE, 0, 0, 255, 255, 63, 0, 1, 1);   // bounds wins over capacity
    send_req(CMD_TILE, 0, 0, 64, 32, 0, 0, 1, 1);      // capacity exactly at limit
    send_req(CMD_TILE, 0, 0, 1, 1, 49, 29, 1, 1);      // last corner byte
    send_req(CMD_TILE, 0, 0, 3, 2, 0, 0, 50, 30);      // whole screen, wrapping source
    send_req(CMD_TILE, 0, 0, 4, 3, 10, 5, 20, 8);
  endtask

  task automatic test_flush_and_show();
    send_req(CMD_FLUSH);     // tiles drawn so far go on show at the first frame start
    random_tile();           // lands in the new drawing frame, not on screen
    test_serial_bytes(120);  // header, the first two lines and part of the third
    send_req(CMD_FLUSH);     // lands mid-frame, visible only at next frame start
    random_tile();
  endtask

  // Receiver holds off while the sender keeps offering; then sender waits for all
  task automatic test_backpressure();
    hold_len = 400;
    for (int i = 0; i < 40; i++) send_req(CMD_NEXT);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int pick, sw, sh;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);  // long stretch without idling
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(3) == 0) send_req(CMD_LOAD, $urandom_range(0, SRC_BYTES - 1), $urandom);
        else send_req(CMD_LOAD, $urandom_range(0, src_prefix - 1), $urandom);
      end else if (pick < 45) begin
        if ($urandom_range(4) == 0) begin
          sw = $urandom_range(0, 255);
          sh = $urandom_range(0, 255);
          // a tile that passes the capacity check must only read loaded bytes
          if (sw * sh * 8 <= SRC_BYTES && sw * sh * 8 > src_prefix) begin
            sw = 1;
            sh = 1;
          end
          send_req(CMD_TILE, $urandom, $urandom, sw, sh, $urandom_range(0, 63),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 31));
        end else random_tile();
      end else if (pick < 46) begin
        send_req(CMD_FLUSH);
      end else begin
        send_req(CMD_NEXT);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    shown = 0; pending = 0; drawing = 1; spare = 2; vcom = 1'b0; tx_pos = 0;
    src_prefix = 0;
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < FRAME_DATA; i++) frame_mem[f][i] = (f < 2) ? 8'hFF : 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_source_load();
    test_tile_args();
    test_flush_and_show();
    test_backpressure();
    test_random(535);
    send_req(CMD_FLUSH);
    test_serial_bytes(30);

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Run: %0d requests, %0d replies checked, %0d frames sent end to end,",
             n_sent, n_checked, n_frames);
    $display("     %0d tiles drawn, %0d flushes, %0d mismatches", n_tiles_ok, n_flush, errors);
    if (errors == 0 && reply_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
